/* rtl/core/ffha_pkg.sv */
// Shared constants, types and command structures of the first-fit heap allocator.
package ffha_pkg;

  localparam int HEAP_DEPTH = 4096;
  localparam int MAX_BLOCKS = 64;
  localparam int HEAP_AW = $clog2(HEAP_DEPTH);
  localparam int TBL_AW = $clog2(MAX_BLOCKS);
  localparam int START_W = HEAP_AW;
  localparam int SIZE_W = HEAP_AW + 1;
  localparam int CNT_W = TBL_AW + 1;
  localparam int TBL_W = START_W + SIZE_W + 1;
  localparam logic [30:0] BASE_RESET = 31'd10000;
  localparam logic [32:0] ADDR_MAX = 33'h0_7FFF_FFFF;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STS_OK      = 3'd0,
    STS_BAD     = 3'd1,
    STS_NOSPACE = 3'd2,
    STS_NOTHEAP = 3'd3,
    STS_NOBLOCK = 3'd4,
    STS_OUTSIDE = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_RD, S_CHK, S_MISS, S_SPLIT_NEW, S_SPLIT_OLD,
    S_TAKE, S_FREE, S_ZERO, S_HREAD, S_HWAIT, S_HWRITE, S_FINISH
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    decode;
    logic    check;
    logic    clr_step;
    logic    split_new;
    logic    split_old;
    logic    take;
    logic    mark_free;
    logic    zero_step;
    logic    heap_wr;
    logic    append;
    logic    res_heap;
    logic    publish;
    logic    st_load;
    status_t st_code;
  } cmd_t;

  typedef struct packed {
    logic    clr_done;
    logic    early_err;
    status_t early_code;
    logic    scan_end;
    logic    match;
    logic    split_need;
    logic    table_full;
    logic    append_fail;
    logic    zero_done;
    logic    out_free;
    op_t     op;
  } sts_t;

endpackage

/* rtl/core/ffha_if.sv */
// Valid/ready channel interfaces for the allocator's requests and responses.
interface ffha_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic signed [31:0] alloc_words;
  logic signed [31:0] address;
  logic signed [31:0] write_value;

  modport source (output valid, operation, alloc_words, address, write_value, input ready);
  modport sink (input valid, operation, alloc_words, address, write_value, output ready);
endinterface

interface ffha_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic signed [31:0] result_value;

  modport source (output valid, status, result_value, input ready);
  modport sink (input valid, status, result_value, output ready);
endinterface

/* rtl/core/first_fit_heap_allocator_core.sv */
// Top level of the first-fit heap allocator: controller, datapath and checks.
// Requests arrive on in_ch (operation, alloc_words, address, write_value) and
// each request yields exactly one response on out_ch (status, result_value).
// The heap base register is written through cfg_we and cfg_data; the user must
// write it only while idle, which the block itself does not enforce.
// One item is worked on at a time. The controller walks the block table one
// entry at a time through the table RAM's registered read port, scanning at
// most the 64 entries of a full table; a request rejected at decode skips the scan.
// Freeing also clears every word of the block, one word per cycle through
// the heap RAM's single write port.
// After reset all 4096 words of the heap RAM are cleared, during which
// in_ch.ready stays low; the heap base returns to 10000 and the table empties.
// The response sits in an output register until it is taken; the next item
// can be accepted meanwhile, and its response waits until out_ch is free.
module first_fit_heap_allocator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [30:0] cfg_data,
  ffha_in_if.sink     in_ch,
  ffha_out_if.source  out_ch
);

  ffha_pkg::cmd_t cmd;
  ffha_pkg::sts_t sts;

  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffha_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .in_operation     (in_ch.operation),
    .in_alloc_words   (in_ch.alloc_words),
    .in_address       (in_ch.address),
    .in_write_value   (in_ch.write_value),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_status       (out_ch.status),
    .out_result_value (out_ch.result_value),
    .cmd              (cmd),
    .sts              (sts)
  );

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("A second item was accepted while one was in progress.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!out_ch.valid || out_ch.ready))
    else $error("A pending response was overwritten.");

  a_split_room: assert property (@(posedge clk) disable iff (rst)
    cmd.split_new |-> !sts.table_full)
    else $error("A split was made into a full block table.");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> !sts.append_fail)
    else $error("A block was appended without room for it.");

endmodule

/* rtl/core/ffha_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/ffha_ctrl.sv */
// Controller state machine that sequences table scans, updates and heap accesses.
module ffha_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ffha_pkg::sts_t   sts,
  output ffha_pkg::cmd_t   cmd
);

  ffha_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffha_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ffha_pkg::S_CLEAR: if (sts.clr_done) state_next = ffha_pkg::S_IDLE;
      ffha_pkg::S_IDLE: if (in_valid) state_next = ffha_pkg::S_DECODE;
      ffha_pkg::S_DECODE: begin
        state_next = sts.early_err ? ffha_pkg::S_FINISH : ffha_pkg::S_RD;
      end
      ffha_pkg::S_RD: state_next = sts.scan_end ? ffha_pkg::S_MISS : ffha_pkg::S_CHK;
      ffha_pkg::S_CHK: begin
        if (!sts.match) begin
          state_next = ffha_pkg::S_RD;
        end else begin
          unique case (sts.op)
            ffha_pkg::OP_ALLOC: begin
              if (!sts.split_need) state_next = ffha_pkg::S_TAKE;
              else if (sts.table_full) state_next = ffha_pkg::S_FINISH;
              else state_next = ffha_pkg::S_SPLIT_NEW;
            end
            ffha_pkg::OP_FREE: state_next = ffha_pkg::S_FREE;
            ffha_pkg::OP_READ: state_next = ffha_pkg::S_HREAD;
            ffha_pkg::OP_WRITE: state_next = ffha_pkg::S_HWRITE;
            default: state_next = ffha_pkg::S_FINISH;
          endcase
        end
      end
      ffha_pkg::S_MISS: state_next = ffha_pkg::S_FINISH;
      ffha_pkg::S_SPLIT_NEW: state_next = ffha_pkg::S_SPLIT_OLD;
      ffha_pkg::S_SPLIT_OLD: state_next = ffha_pkg::S_FINISH;
      ffha_pkg::S_TAKE: state_next = ffha_pkg::S_FINISH;
      ffha_pkg::S_FREE: state_next = ffha_pkg::S_ZERO;
      ffha_pkg::S_ZERO: if (sts.zero_done) state_next = ffha_pkg::S_FINISH;
      ffha_pkg::S_HREAD: state_next = ffha_pkg::S_HWAIT;
      ffha_pkg::S_HWAIT: state_next = ffha_pkg::S_FINISH;
      ffha_pkg::S_HWRITE: state_next = ffha_pkg::S_FINISH;
      ffha_pkg::S_FINISH: if (sts.out_free) state_next = ffha_pkg::S_IDLE;
      default: state_next = ffha_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.st_code = ffha_pkg::STS_OK;
    in_ready = 1'b0;
    unique case (state)
      ffha_pkg::S_CLEAR: cmd.clr_step = 1'b1;
      ffha_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.capture = in_valid;
      end
      ffha_pkg::S_DECODE: begin
        cmd.decode = 1'b1;
        cmd.st_load = sts.early_err;
        cmd.st_code = sts.early_code;
      end
      ffha_pkg::S_RD: ;
      ffha_pkg::S_CHK: begin
        cmd.check = 1'b1;
        if (sts.match && sts.op == ffha_pkg::OP_ALLOC && sts.split_need && sts.table_full) begin
          cmd.st_load = 1'b1;
          cmd.st_code = ffha_pkg::STS_NOSPACE;
        end
      end
      ffha_pkg::S_MISS: begin
        unique case (sts.op)
          ffha_pkg::OP_ALLOC: begin
            cmd.append = !sts.append_fail;
            cmd.st_load = sts.append_fail;
            cmd.st_code = ffha_pkg::STS_NOSPACE;
          end
          ffha_pkg::OP_FREE: begin
            cmd.st_load = 1'b1;
            cmd.st_code = ffha_pkg::STS_NOBLOCK;
          end
          default: begin
            cmd.st_load = 1'b1;
            cmd.st_code = ffha_pkg::STS_OUTSIDE;
          end
        endcase
      end
      ffha_pkg::S_SPLIT_NEW: cmd.split_new = 1'b1;
      ffha_pkg::S_SPLIT_OLD: begin
        cmd.split_old = 1'b1;
        cmd.take = 1'b1;
      end
      ffha_pkg::S_TAKE: cmd.take = 1'b1;
      ffha_pkg::S_FREE: cmd.mark_free = 1'b1;
      ffha_pkg::S_ZERO: cmd.zero_step = !sts.zero_done;
      ffha_pkg::S_HREAD: ;
      ffha_pkg::S_HWAIT: cmd.res_heap = 1'b1;
      ffha_pkg::S_HWRITE: cmd.heap_wr = 1'b1;
      ffha_pkg::S_FINISH: cmd.publish = sts.out_free;
      default: ;
    endcase
  end

endmodule

/* rtl/core/ffha_dp.sv */
// Datapath with the block table, heap word store, request registers and output register.
module ffha_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [30:0]         cfg_data,
  input  logic [1:0]          in_operation,
  input  logic signed [31:0]  in_alloc_words,
  input  logic signed [31:0]  in_address,
  input  logic signed [31:0]  in_write_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_status,
  output logic signed [31:0]  out_result_value,
  input  ffha_pkg::cmd_t      cmd,
  output ffha_pkg::sts_t      sts
);

  logic [30:0] base;
  ffha_pkg::op_t op;
  logic [31:0] req;
  logic [31:0] addr;
  logic [31:0] wval;
  logic [31:0] off;
  logic [ffha_pkg::CNT_W-1:0] count;
  logic [ffha_pkg::CNT_W-1:0] idx;
  logic [ffha_pkg::SIZE_W-1:0] top;
  logic [ffha_pkg::START_W-1:0] hstart;
  logic [ffha_pkg::SIZE_W-1:0] hsize;
  logic [ffha_pkg::HEAP_AW-1:0] clr_ptr;
  logic [ffha_pkg::HEAP_AW-1:0] zptr;
  logic [ffha_pkg::SIZE_W-1:0] zcnt;
  ffha_pkg::status_t status;
  logic [31:0] result;

  logic [ffha_pkg::TBL_W-1:0] tbl_rdata;
  logic [ffha_pkg::TBL_W-1:0] tbl_wdata;
  logic [ffha_pkg::TBL_AW-1:0] tbl_waddr;
  logic tbl_we;
  logic [ffha_pkg::START_W-1:0] e_start;
  logic [ffha_pkg::SIZE_W-1:0] e_size;
  logic [ffha_pkg::SIZE_W-1:0] e_end;
  logic e_used;
  logic [ffha_pkg::START_W-1:0] off_rel;

  logic heap_we;
  logic [ffha_pkg::HEAP_AW-1:0] heap_waddr;
  logic [31:0] heap_wdata;
  logic [31:0] heap_rdata;

  logic [31:0] off_c;
  logic [32:0] top_sum;
  logic [32:0] addr_sum;
  logic [31:0] take_addr;

  assign e_used = tbl_rdata[ffha_pkg::TBL_W-1];
  assign e_start = tbl_rdata[ffha_pkg::TBL_W-2:ffha_pkg::SIZE_W];
  assign e_size = tbl_rdata[ffha_pkg::SIZE_W-1:0];
  assign e_end = {1'b0, e_start} + e_size;
  assign off_rel = off[ffha_pkg::START_W-1:0] - e_start;
  assign off_c = addr - {1'b0, base};
  assign top_sum = {20'd0, top} + {1'b0, req};
  assign addr_sum = {2'd0, base} + {20'd0, top} + {1'b0, req};
  assign take_addr = {1'b0, base} + {20'd0, hstart};

  always_comb begin
    sts.clr_done = clr_ptr == ffha_pkg::HEAP_AW'(ffha_pkg::HEAP_DEPTH - 1);
    sts.early_err = 1'b0;
    sts.early_code = ffha_pkg::STS_OK;
    if (op == ffha_pkg::OP_ALLOC) begin
      if (req[31] || req == 32'd0) begin
        sts.early_err = 1'b1;
        sts.early_code = ffha_pkg::STS_BAD;
      end
    end else if (addr[31]) begin
      sts.early_err = 1'b1;
      sts.early_code = ffha_pkg::STS_BAD;
    end else if (addr < {1'b0, base}) begin
      sts.early_err = 1'b1;
      sts.early_code = ffha_pkg::STS_NOTHEAP;
    end else if (op != ffha_pkg::OP_FREE && off_c >= 32'(ffha_pkg::HEAP_DEPTH)) begin
      sts.early_err = 1'b1;
      sts.early_code = ffha_pkg::STS_OUTSIDE;
    end
    sts.scan_end = idx == count;
    case (op)
      ffha_pkg::OP_ALLOC: sts.match = !e_used && {19'd0, e_size} >= req;
      ffha_pkg::OP_FREE: sts.match = e_used && {20'd0, e_start} == off;
      default: begin
        sts.match = e_used && off[ffha_pkg::START_W-1:0] >= e_start
                    && {1'b0, off_rel} < e_size;
      end
    endcase
    sts.split_need = {19'd0, e_size} > req;
    sts.table_full = count == ffha_pkg::CNT_W'(ffha_pkg::MAX_BLOCKS);
    sts.append_fail = sts.table_full || top_sum > 33'(ffha_pkg::HEAP_DEPTH)
                      || addr_sum > ffha_pkg::ADDR_MAX;
    sts.zero_done = zcnt == '0;
    sts.out_free = !out_valid || out_ready;
    sts.op = op;
  end

  always_comb begin
    tbl_we = 1'b0;
    tbl_waddr = idx[ffha_pkg::TBL_AW-1:0];
    tbl_wdata = {1'b1, hstart, hsize};
    if (cmd.append) begin
      tbl_we = 1'b1;
      tbl_waddr = count[ffha_pkg::TBL_AW-1:0];
      tbl_wdata = {1'b1, top[ffha_pkg::START_W-1:0], req[ffha_pkg::SIZE_W-1:0]};
    end else if (cmd.split_new) begin
      tbl_we = 1'b1;
      tbl_waddr = count[ffha_pkg::TBL_AW-1:0];
      tbl_wdata = {1'b0, hstart + req[ffha_pkg::START_W-1:0],
                   hsize - req[ffha_pkg::SIZE_W-1:0]};
    end else if (cmd.split_old) begin
      tbl_we = 1'b1;
      tbl_wdata = {1'b1, hstart, req[ffha_pkg::SIZE_W-1:0]};
    end else if (cmd.take) begin
      tbl_we = 1'b1;
    end else if (cmd.mark_free) begin
      tbl_we = 1'b1;
      tbl_wdata = {1'b0, hstart, hsize};
    end
  end

  always_comb begin
    heap_we = cmd.clr_step || cmd.zero_step || cmd.heap_wr;
    heap_waddr = off[ffha_pkg::HEAP_AW-1:0];
    heap_wdata = '0;
    if (cmd.clr_step) begin
      heap_waddr = clr_ptr;
    end else if (cmd.zero_step) begin
      heap_waddr = zptr;
    end else begin
      heap_wdata = wval;
    end
  end

  ffha_ram #(.WIDTH(ffha_pkg::TBL_W), .DEPTH(ffha_pkg::MAX_BLOCKS)) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (idx[ffha_pkg::TBL_AW-1:0]),
    .rdata (tbl_rdata)
  );

  ffha_ram #(.WIDTH(32), .DEPTH(ffha_pkg::HEAP_DEPTH)) u_heap (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (off[ffha_pkg::HEAP_AW-1:0]),
    .rdata (heap_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= ffha_pkg::BASE_RESET;
      count <= '0;
      clr_ptr <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) base <= cfg_data;
      if (cmd.clr_step) clr_ptr <= clr_ptr + 1'b1;
      if (cmd.append || cmd.split_new) count <= count + 1'b1;
      if (cmd.publish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op <= ffha_pkg::op_t'(in_operation);
      req <= in_alloc_words;
      addr <= in_address;
      wval <= in_write_value;
      status <= ffha_pkg::STS_OK;
      result <= '0;
    end
    if (cmd.decode) begin
      off <= off_c;
      idx <= '0;
      top <= '0;
    end
    if (cmd.check) begin
      hstart <= e_start;
      hsize <= e_size;
      if (!sts.match) begin
        idx <= idx + 1'b1;
        if (e_end > top) top <= e_end;
      end
    end
    if (cmd.st_load) status <= cmd.st_code;
    if (cmd.take) result <= take_addr;
    if (cmd.append) result <= {1'b0, base} + {19'd0, top};
    if (cmd.res_heap) result <= heap_rdata;
    if (cmd.mark_free) begin
      zptr <= hstart;
      zcnt <= hsize;
    end
    if (cmd.zero_step) begin
      zptr <= zptr + 1'b1;
      zcnt <= zcnt - 1'b1;
    end
    if (cmd.publish) begin
      out_status <= status;
      out_result_value <= result;
    end
  end

endmodule
